>>> rtl/kdm_pkg.sv
// ----------------------------------------------------------------------------
// kdm_pkg: shared types and constants for the key debounce / multi-click core
// Holds time and count widths, event codes, register indexes and the
// configuration and result structs used across the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdm_pkg;

	// widths
	localparam int TIME_BITS     = 32;
	localparam int COUNT_BITS    = 8;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int EVENT_BITS    = 2;

	// reset values of the configuration registers
	localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RST = CFG_DATA_BITS'(2);
	localparam logic [CFG_DATA_BITS-1:0] GAP_RST      = CFG_DATA_BITS'(30);
	localparam logic                     ACTIVE_RST   = 1'b0;
	localparam logic                     ENABLE_RST   = 1'b1;

	// event codes reported per tick
	typedef enum logic [EVENT_BITS-1:0] {
		EV_NONE    = 2'd0,
		EV_FIRST   = 2'd1,
		EV_HELD    = 2'd2,
		EV_RELEASE = 2'd3
	} event_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_GAP      = 2'd1,
		REG_ACTIVE   = 2'd2,
		REG_ENABLE   = 2'd3
	} cfg_reg_t;

	// current configuration, register file to scan logic
	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] debounce_ticks;
		logic [CFG_DATA_BITS-1:0] gap_ticks;
		logic                     active_level;
		logic                     key_enable;
	} cfg_t;

	// one result item
	typedef struct packed {
		event_t                  event_res;
		logic [COUNT_BITS-1:0]   click_count;
		logic [TIME_BITS-1:0]    duration;
	} res_t;

endpackage

>>> rtl/kdm_if.sv
// ----------------------------------------------------------------------------
// kdm_if: valid/ready channels of the key debounce / multi-click core
// Key sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kdm_sample_if;
	logic valid;
	logic ready;
	logic raw_level;

	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

interface kdm_result_if
	import kdm_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [EVENT_BITS-1:0] event_res;
	logic [COUNT_BITS-1:0] click_count;
	logic [TIME_BITS-1:0]  duration;

	modport source (output valid, output event_res, output click_count, output duration,
		input ready);
	modport sink (input valid, input event_res, input click_count, input duration,
		output ready);
endinterface

interface kdm_cfg_if
	import kdm_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/kdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdm_cfg_regs: configuration register file
// Takes one register write per transaction; always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdm_cfg_regs
	import kdm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	kdm_cfg_if.sink   cfg,
	output cfg_t      cfg_cur
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_cur   = regs_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ticks <= DEBOUNCE_RST;
			regs_q.gap_ticks      <= GAP_RST;
			regs_q.active_level   <= ACTIVE_RST;
			regs_q.key_enable     <= ENABLE_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_DEBOUNCE: regs_q.debounce_ticks <= cfg.data;
				REG_GAP:      regs_q.gap_ticks      <= cfg.data;
				REG_ACTIVE:   regs_q.active_level   <= cfg.data[0];
				REG_ENABLE:   regs_q.key_enable     <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/kdm_scan.sv
// ----------------------------------------------------------------------------
// kdm_scan: debounce and gesture state with single-pass tick update
// Holds the key state; computes the tick result and next state in one pass
// and commits the state on each accepted sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdm_scan
	import kdm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step_en,
	input  logic  raw_level,
	input  cfg_t  cfg_cur,
	output res_t  res
);

	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	// key state
	logic [TIME_BITS-1:0]  tick_now_q;
	logic                  stable_q;
	logic                  prev_stable_q;
	logic                  in_gesture_q;
	logic                  prev_in_gesture_q;
	logic                  settling_q;
	logic [TIME_BITS-1:0]  edge_time_q;
	logic [TIME_BITS-1:0]  start_time_q;
	logic [COUNT_BITS-1:0] clicks_q;

	// next state
	logic                  stable_d;
	logic                  prev_stable_d;
	logic                  in_gesture_d;
	logic                  prev_in_gesture_d;
	logic                  settling_d;
	logic [TIME_BITS-1:0]  edge_time_d;
	logic [TIME_BITS-1:0]  start_time_d;
	logic [COUNT_BITS-1:0] clicks_d;

	// intermediates
	logic                  ig0;
	logic                  set0;
	logic [COUNT_BITS-1:0] clk0;
	logic                  change;
	logic                  db_done;
	logic                  gap_done;
	logic                  scan;
	logic                  pressed;
	logic [TIME_BITS-1:0]  since_edge;
	logic [TIME_BITS-1:0]  rel_dur;

	// debounce, then gesture scan
	always_comb begin
		// disabled key drops gesture, count and settling first
		ig0  = cfg_cur.key_enable ? in_gesture_q : 1'b0;
		set0 = cfg_cur.key_enable ? settling_q : 1'b0;
		clk0 = cfg_cur.key_enable ? clicks_q : '0;

		stable_d          = stable_q;
		prev_stable_d     = prev_stable_q;
		in_gesture_d      = ig0;
		prev_in_gesture_d = prev_in_gesture_q;
		start_time_d      = start_time_q;
		clicks_d          = clk0;
		res.event_res     = EV_NONE;
		res.click_count   = '0;
		res.duration      = '0;

		// debounce
		change      = (stable_q != raw_level) || ((stable_q == cfg_cur.active_level) && !ig0);
		edge_time_d = (change && !set0) ? tick_now_q : edge_time_q;
		since_edge  = tick_now_q - edge_time_d;
		db_done     = since_edge >= TIME_BITS'(cfg_cur.debounce_ticks);
		gap_done    = since_edge >= TIME_BITS'(cfg_cur.gap_ticks);
		if (change) begin
			if (db_done) begin
				settling_d = 1'b0;
				stable_d   = raw_level;
			end else begin
				settling_d = 1'b1;
			end
		end else begin
			settling_d = 1'b0;
		end

		// gesture scan
		scan    = !settling_d || ig0;
		pressed = stable_d == cfg_cur.active_level;
		rel_dur = tick_now_q - start_time_q - TIME_BITS'(cfg_cur.gap_ticks);
		if (scan) begin
			if (pressed) begin
				in_gesture_d = 1'b1;
				if (!ig0) begin
					start_time_d = edge_time_d;
				end
				if ((prev_stable_q != stable_d) && (clk0 != CMAX)) begin
					clicks_d = clk0 + COUNT_BITS'(1);
				end
				res.event_res   = prev_in_gesture_q ? EV_HELD : EV_FIRST;
				res.click_count = clicks_d;
				res.duration    = tick_now_q - start_time_d;
			end else if (gap_done && ig0) begin
				res.event_res   = EV_RELEASE;
				res.click_count = clk0;
				res.duration    = rel_dur;
				start_time_d    = rel_dur;
				in_gesture_d    = 1'b0;
				clicks_d        = '0;
			end
			prev_in_gesture_d = in_gesture_d;
			prev_stable_d     = stable_d;
		end
	end

	// state commit per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now_q        <= '0;
			stable_q          <= 1'b0;
			prev_stable_q     <= 1'b0;
			in_gesture_q      <= 1'b0;
			prev_in_gesture_q <= 1'b0;
			settling_q        <= 1'b0;
			edge_time_q       <= '0;
			start_time_q      <= '0;
			clicks_q          <= '0;
		end else if (step_en) begin
			tick_now_q        <= tick_now_q + TIME_BITS'(1);
			stable_q          <= stable_d;
			prev_stable_q     <= prev_stable_d;
			in_gesture_q      <= in_gesture_d;
			prev_in_gesture_q <= prev_in_gesture_d;
			settling_q        <= settling_d;
			edge_time_q       <= edge_time_d;
			start_time_q      <= start_time_d;
			clicks_q          <= clicks_d;
		end
	end

endmodule

>>> rtl/key_debounce_multiclick_core.sv
// ----------------------------------------------------------------------------
// key_debounce_multiclick_core: key debounce and multi-click gesture timer
// Result is valid in the cycle after the sample transaction.
// One sample per cycle unless the result stalls; key state and result update together.
// Reset: arst_n clears key state, tick counter and result valid; registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_debounce_multiclick_core
	import kdm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	kdm_sample_if.sink     sample,
	kdm_result_if.source   result,
	kdm_cfg_if.sink        cfg
);

	cfg_t cfg_cur;
	res_t res_comb;
	res_t res_q;
	logic out_valid_q;
	logic accept;

	kdm_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_cur (cfg_cur)
	);

	kdm_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (accept),
		.raw_level (sample.raw_level),
		.cfg_cur   (cfg_cur),
		.res       (res_comb)
	);

	// take a sample whenever the result register is free or draining
	assign sample.ready = !out_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_comb;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.event_res   = res_q.event_res;
	assign result.click_count = res_q.click_count;
	assign result.duration    = res_q.duration;

`ifndef SYNTHESIS
	// every sample transaction yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> result.valid)
		else $error("no result after sample transaction");

	// no-event results carry zero count and duration
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.event_res == EV_NONE)
		|-> (result.click_count == '0) && (result.duration == '0))
		else $error("nonzero payload on no-event result");

	// a stalled result is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !sample.ready)
		else $error("sample taken while result stalled");
`endif

endmodule

>>> bench/tb_key_debounce_multiclick_core.sv
// ----------------------------------------------------------------------------
// tb_key_debounce_multiclick_core: self-checking bench for the key scanner
// Feeds scan ticks through the sample channel, mirrors the debounce and
// gesture logic in a local model, and checks every result transaction field
// by field. Runs directed ticks, then gesture-shaped random traffic over
// several register settings and handshake load patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_key_debounce_multiclick_core;
	import kdm_pkg::*;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// channel drive variables, known from time zero
	logic                     smp_valid = 1'b0;
	logic                     smp_raw   = 1'b0;
	logic                     res_ready = 1'b0;
	logic                     cfg_valid = 1'b0;
	cfg_reg_t                 cfg_index = REG_DEBOUNCE;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	kdm_sample_if smp_if ();
	kdm_result_if res_if ();
	kdm_cfg_if    cfg_if ();

	assign smp_if.valid     = smp_valid;
	assign smp_if.raw_level = smp_raw;
	assign res_if.ready     = res_ready;
	assign cfg_if.valid     = cfg_valid;
	assign cfg_if.index     = cfg_index;
	assign cfg_if.data      = cfg_data;

	key_debounce_multiclick_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	// stimulus and scoreboard storage
	logic key_samples[$];
	res_t pending_events[$];
	res_t next_event;
	int   samples_queued = 0;
	int   samples_taken  = 0;
	int   n_errors       = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;

	// mirror of the register file
	cfg_t key_cfg = '{DEBOUNCE_RST, GAP_RST, ACTIVE_RST, ENABLE_RST};

	// mirror of the key state
	logic [TIME_BITS-1:0]  k_now        = '0;
	logic [TIME_BITS-1:0]  k_edge_at    = '0;
	logic [TIME_BITS-1:0]  k_start_at   = '0;
	logic [COUNT_BITS-1:0] k_clicks     = '0;
	logic                  k_stable     = 1'b0;
	logic                  k_last_stbl  = 1'b0;
	logic                  k_open       = 1'b0;
	logic                  k_last_open  = 1'b0;
	logic                  k_settling   = 1'b0;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// one scan tick of the key: debounce, then gesture scan
	function automatic res_t predict_scan(input logic raw);
		res_t                 r;
		logic [TIME_BITS-1:0] since;
		r = '0;
		r.event_res = EV_NONE;
		if (!key_cfg.key_enable) begin
			k_open     = 1'b0;
			k_clicks   = '0;
			k_settling = 1'b0;
		end

		// debounce; a pressed level with no open gesture keeps it running
		if (k_stable != raw || (k_stable == key_cfg.active_level && !k_open)) begin
			if (!k_settling)
				k_edge_at = k_now;
			since = k_now - k_edge_at;
			if (since >= TIME_BITS'(key_cfg.debounce_ticks)) begin
				k_settling = 1'b0;
				k_stable   = raw;
			end else begin
				k_settling = 1'b1;
			end
		end else begin
			k_settling = 1'b0;
		end

		// gesture scan, still active while settling inside a gesture
		if (!k_settling || k_open) begin
			since = k_now - k_edge_at;
			if (k_stable == key_cfg.active_level) begin
				if (!k_open) begin
					k_start_at = k_edge_at;
					k_open     = 1'b1;
				end
				if (k_last_stbl != k_stable && k_clicks != '1)
					k_clicks = k_clicks + COUNT_BITS'(1);
				r.event_res   = (k_open == k_last_open) ? EV_HELD : EV_FIRST;
				r.click_count = k_clicks;
				r.duration    = k_now - k_start_at;
			end else if (since >= TIME_BITS'(key_cfg.gap_ticks) && k_open) begin
				// duration excludes the release gap and may wrap
				r.event_res   = EV_RELEASE;
				r.click_count = k_clicks;
				r.duration    = k_now - k_start_at - TIME_BITS'(key_cfg.gap_ticks);
				k_start_at    = r.duration;
				k_open        = 1'b0;
				k_clicks      = '0;
			end
			k_last_open = k_open;
			k_last_stbl = k_stable;
		end

		k_now = k_now + TIME_BITS'(1);
		return r;
	endfunction

	// sample driver: presents queued ticks, predicts on each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid <= 1'b0;
			smp_raw   <= 1'b0;
		end else begin
			if (smp_valid && smp_if.ready) begin
				pending_events.push_back(predict_scan(smp_raw));
				samples_taken++;
			end
			if (!smp_valid || smp_if.ready) begin
				if (key_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					smp_valid <= 1'b1;
					smp_raw   <= key_samples.pop_front();
				end else begin
					smp_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			n_errors++;
		end
	endtask

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_if.valid && res_ready) begin
				if (pending_events.size() == 0) begin
					$display("%0t ns: result with nothing expected, expected none, got %0d/%0d/%0d",
						$time, res_if.event_res, res_if.click_count, res_if.duration);
					n_errors++;
				end else begin
					next_event = pending_events.pop_front();
					check_field("event_res", 32'(next_event.event_res), 32'(res_if.event_res));
					check_field("click_count", 32'(next_event.click_count),
						32'(res_if.click_count));
					check_field("duration", next_event.duration, res_if.duration);
				end
			end
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// register write over the config channel; mirror updated on the transaction
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DEBOUNCE: key_cfg.debounce_ticks = val;
			REG_GAP:      key_cfg.gap_ticks      = val;
			REG_ACTIVE:   key_cfg.active_level   = val[0];
			REG_ENABLE:   key_cfg.key_enable     = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int deb, input int gap, input logic act, input logic en);
		write_reg(REG_DEBOUNCE, CFG_DATA_BITS'(deb));
		write_reg(REG_GAP, CFG_DATA_BITS'(gap));
		write_reg(REG_ACTIVE, CFG_DATA_BITS'(act));
		write_reg(REG_ENABLE, CFG_DATA_BITS'(en));
	endtask

	task automatic set_load(input int send_pct, input int stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic put_level(input logic lvl, input int n);
		repeat (n) key_samples.push_back(lvl);
		samples_queued += n;
	endtask

	task automatic add_noise(input int n);
		repeat (n) put_level(1'($urandom_range(1)), 1);
	endtask

	// multi-click gesture shaped around the current debounce and gap times
	task automatic add_gesture();
		int   d;
		int   g;
		int   presses;
		int   span;
		logic act;
		d = (key_cfg.debounce_ticks > 8) ? 8 : int'(key_cfg.debounce_ticks);
		g = (key_cfg.gap_ticks > 40) ? 40 : int'(key_cfg.gap_ticks);
		act = key_cfg.active_level;
		presses = $urandom_range(4, 1);
		for (int k = 0; k < presses; k++) begin
			// contact bounce at the press
			if ($urandom_range(3) == 0) begin
				put_level(act, 1);
				put_level(!act, 1);
			end
			put_level(act, d + 1 + $urandom_range(4));
			if (k < presses - 1) begin
				span = (g > d + 1) ? $urandom_range(g, d + 1) : d + 1;
				put_level(!act, span);
			end
		end
		put_level(!act, g + d + 2 + $urandom_range(3));
	endtask

	// wait until every queued tick has gone through and been checked
	task automatic drain();
		while (samples_taken != samples_queued || pending_events.size() != 0)
			@(posedge clk);
	endtask

	// main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: press, bounce while held, second click, release after gap
		set_regs(1, 4, 1'b0, 1'b1);
		set_load(0, 0);
		put_level(1'b0, 4);
		put_level(1'b1, 1);
		put_level(1'b0, 2);
		put_level(1'b1, 3);
		put_level(1'b0, 3);
		put_level(1'b1, 8);
		drain();

		// zero debounce and zero gap, active high
		set_regs(0, 0, 1'b1, 1'b1);
		repeat (3) add_gesture();
		add_noise(10);
		drain();

		// sender idling
		set_regs(3, 10, 1'b0, 1'b1);
		set_load(63, 0);
		repeat (2) add_gesture();
		add_noise(10);
		drain();

		// click count saturation under a gap that never expires
		set_regs(0, 65535, 1'b1, 1'b1);
		set_load(37, 37);
		repeat (258) begin
			put_level(1'b1, 1);
			put_level(1'b0, 1);
		end
		add_noise(10);
		drain();

		// disabled key: state cleared on every tick
		write_reg(REG_ENABLE, CFG_DATA_BITS'(0));
		write_reg(REG_DEBOUNCE, CFG_DATA_BITS'(2));
		write_reg(REG_GAP, CFG_DATA_BITS'(5));
		set_load(0, 63);
		add_noise(30);
		add_gesture();
		drain();

		// debounce time that never elapses within the phase
		set_regs(65535, 20, 1'b0, 1'b1);
		set_load(37, 37);
		add_noise(10);
		add_gesture();
		drain();

		// back to moderate timing, receiver stalling
		set_regs(2, 8, 1'b0, 1'b1);
		set_load(0, 63);
		repeat (2) add_gesture();
		add_noise(10);
		set_load(0, 0);
		drain();

		repeat (4) @(posedge clk);
		if (n_errors == 0 && pending_events.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/kdm_pkg.sv
rtl/kdm_if.sv
rtl/kdm_cfg_regs.sv
rtl/kdm_scan.sv
rtl/key_debounce_multiclick_core.sv
bench/tb_key_debounce_multiclick_core.sv
